FILE: rtl/itk_pkg.sv
// Shared constants, widths and tables for the trimmer inverse kinematics pipeline.
`timescale 1ns / 1ps
package itk_pkg;

   localparam int ANGLE_MIN    = -23040;
   localparam int ANGLE_MAX    = 23040;
   localparam int CORDIC_STEPS = 16;
   localparam int MAX_STEPS    = 24;

   localparam int SQRT_STEPS = 32;

   localparam int POS_W  = 24;
   localparam int ANG_W  = 18;
   localparam int TURN_W = 17;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam int SC_W  = 33;
   localparam int SZ_W  = 35;
   localparam int AT_W  = 36;
   localparam int AZ_W  = 35;
   localparam int PRD_W = 57;
   localparam int ACC_W = 60;

   localparam int DEG90  = 23040;
   localparam int DEG180 = 46080;
   localparam int DEG360 = 92160;
   localparam int LIFT_MARGIN = 512;
   localparam logic [31:0] GAIN_Q30 = 32'd652032874;

   localparam logic [2:0] REG_ARM_REACH   = 3'd0;
   localparam logic [2:0] REG_BASE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TOOL_ALONG  = 3'd2;
   localparam logic [2:0] REG_TOOL_ACROSS = 3'd3;
   localparam logic [2:0] REG_LIFT_MIN    = 3'd4;
   localparam logic [2:0] REG_LIFT_MAX    = 3'd5;
   localparam logic [2:0] REG_HEIGHT_MIN  = 3'd6;
   localparam logic [2:0] REG_HEIGHT_MAX  = 3'd7;

   localparam logic [30:0] ATAN_TABLE [0:MAX_STEPS-1] = '{
      31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938,
      31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
      31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
      31'd234684,    31'd117342,    31'd58671,     31'd29335,
      31'd14668,     31'd7334,      31'd3667,      31'd1833,
      31'd917,       31'd458,       31'd229,       31'd115
   };

endpackage

FILE: rtl/itk_if.sv
// Request and response channel interfaces of the trimmer inverse kinematics block.
`timescale 1ns / 1ps
interface itk_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [itk_pkg::POS_W-1:0]     pos_x;
   logic signed [itk_pkg::POS_W-1:0]     pos_y;
   logic signed [itk_pkg::POS_W-1:0]     pos_z;
   logic signed [itk_pkg::ANG_W-1:0]     tilt_angle;

   modport source (output valid, pos_x, pos_y, pos_z, tilt_angle, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, tilt_angle, output ready);
endinterface

interface itk_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [itk_pkg::POS_W-1:0]     lift;
   logic signed [itk_pkg::POS_W-1:0]     height;
   logic signed [itk_pkg::ANG_W-1:0]     cutter_out;
   logic signed [itk_pkg::TURN_W-1:0]    turntable;

   modport source (output valid, lift, height, cutter_out, turntable, input ready);
   modport sink   (input valid, lift, height, cutter_out, turntable, output ready);
endinterface

FILE: rtl/inverse_trimmer_kinematics.sv
// Top level: pipelined inverse kinematics of a four-axis trimming arm.
//
// A request on req carries a target (pos_x, pos_y, pos_z in 1/256 mm) and a
// cutter tilt angle (1/256 degree). Each request gives one response on rsp
// with lift, height, the clamped cutter angle and the turntable angle.
// Geometry offsets and axis limits sit in eight CSR registers at byte address
// 4*i; write them while no request is in flight.
// Throughput: one request per cycle while rsp is not stalled. The 32-step
// square root of the radius sets the pipeline depth; the sine/cosine and
// atan2 CORDICs run alongside it, one rotation per stage for the first
// CORDIC_STEPS stages (at most 24), followed by a multiply stage, a sum stage
// and the rounding and clamping into the output register.
// Reset clears every valid bit and all CSR registers to zero.
// When rsp is stalled the whole pipeline holds and req.ready drops; nothing
// is lost or repeated.
`timescale 1ns / 1ps
module inverse_trimmer_kinematics #(
   parameter int ANGLE_MIN    = itk_pkg::ANGLE_MIN,
   parameter int ANGLE_MAX    = itk_pkg::ANGLE_MAX,
   parameter int CORDIC_STEPS = itk_pkg::CORDIC_STEPS
) (
   input  logic                          clock,
   input  logic                          reset,
   itk_req_if.sink                       req,
   itk_rsp_if.source                     rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [itk_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [itk_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [itk_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int DEPTH = itk_pkg::SQRT_STEPS;
   localparam int NSTEP = (CORDIC_STEPS > itk_pkg::MAX_STEPS) ? itk_pkg::MAX_STEPS
                                                               : CORDIC_STEPS;
   localparam int SC_W  = itk_pkg::SC_W;
   localparam int SZ_W  = itk_pkg::SZ_W;
   localparam int AT_W  = itk_pkg::AT_W;
   localparam int AZ_W  = itk_pkg::AZ_W;
   localparam int PRD_W = itk_pkg::PRD_W;
   localparam int ACC_W = itk_pkg::ACC_W;
   localparam int POS_W = itk_pkg::POS_W;
   localparam int ANG_W = itk_pkg::ANG_W;
   localparam int TURN_W = itk_pkg::TURN_W;

   localparam logic signed [ANG_W-1:0] AMIN = ANG_W'(ANGLE_MIN);
   localparam logic signed [ANG_W-1:0] AMAX = ANG_W'(ANGLE_MAX);
   localparam logic signed [ANG_W:0] D90   = (ANG_W+1)'(itk_pkg::DEG90);
   localparam logic signed [ANG_W:0] D180  = (ANG_W+1)'(itk_pkg::DEG180);
   localparam logic signed [ANG_W:0] D360  = (ANG_W+1)'(itk_pkg::DEG360);
   localparam logic signed [AZ_W-1:0] Z180 =
      AZ_W'(longint'(itk_pkg::DEG180) * 65536);
   localparam logic signed [TURN_W+1:0] T180 = (TURN_W+2)'(itk_pkg::DEG180);

   // configuration registers
   logic [22:0]             arm_reach_ff, base_height_ff;
   logic signed [POS_W-1:0] tool_along_ff, tool_across_ff;
   logic signed [POS_W-1:0] lift_min_ff, lift_max_ff, height_min_ff, height_max_ff;
   logic                    csr_wr;
   logic [2:0]              csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_reach_ff   <= '0;
         base_height_ff <= '0;
         tool_along_ff  <= '0;
         tool_across_ff <= '0;
         lift_min_ff    <= '0;
         lift_max_ff    <= '0;
         height_min_ff  <= '0;
         height_max_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            itk_pkg::REG_ARM_REACH:   arm_reach_ff   <= csr_pwdata[22:0];
            itk_pkg::REG_BASE_HEIGHT: base_height_ff <= csr_pwdata[22:0];
            itk_pkg::REG_TOOL_ALONG:  tool_along_ff  <= $signed(csr_pwdata[23:0]);
            itk_pkg::REG_TOOL_ACROSS: tool_across_ff <= $signed(csr_pwdata[23:0]);
            itk_pkg::REG_LIFT_MIN:    lift_min_ff    <= $signed(csr_pwdata[23:0]);
            itk_pkg::REG_LIFT_MAX:    lift_max_ff    <= $signed(csr_pwdata[23:0]);
            itk_pkg::REG_HEIGHT_MIN:  height_min_ff  <= $signed(csr_pwdata[23:0]);
            itk_pkg::REG_HEIGHT_MAX:  height_max_ff  <= $signed(csr_pwdata[23:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         itk_pkg::REG_ARM_REACH:   csr_prdata = {9'd0, arm_reach_ff};
         itk_pkg::REG_BASE_HEIGHT: csr_prdata = {9'd0, base_height_ff};
         itk_pkg::REG_TOOL_ALONG:  csr_prdata = 32'(tool_along_ff);
         itk_pkg::REG_TOOL_ACROSS: csr_prdata = 32'(tool_across_ff);
         itk_pkg::REG_LIFT_MIN:    csr_prdata = 32'(lift_min_ff);
         itk_pkg::REG_LIFT_MAX:    csr_prdata = 32'(lift_max_ff);
         itk_pkg::REG_HEIGHT_MIN:  csr_prdata = 32'(height_min_ff);
         itk_pkg::REG_HEIGHT_MAX:  csr_prdata = 32'(height_max_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic adv;
   logic out_v_ff;
   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   // stage arrays
   logic                    v_ff    [0:DEPTH];
   logic signed [SC_W-1:0]  sx_ff   [0:DEPTH];
   logic signed [SC_W-1:0]  sy_ff   [0:DEPTH];
   logic signed [SZ_W-1:0]  sz_ff   [0:DEPTH];
   logic                    neg_ff  [0:DEPTH];
   logic signed [AT_W-1:0]  ax_ff   [0:DEPTH];
   logic signed [AT_W-1:0]  ay_ff   [0:DEPTH];
   logic signed [AZ_W-1:0]  az_ff   [0:DEPTH];
   logic                    zero_ff [0:DEPTH];
   logic [63:0]             rem_ff  [0:DEPTH];
   logic [63:0]             root_ff [0:DEPTH];
   logic signed [POS_W-1:0] pz_ff   [0:DEPTH];
   logic signed [ANG_W-1:0] cut_ff  [0:DEPTH];

   // entry stage
   logic signed [ANG_W:0]   a0, a1, a2, a3;
   logic                    neg_in;
   logic signed [ANG_W-1:0] cut_in;
   logic signed [AT_W-1:0]  ax_raw, ay_raw, ax_in, ay_in;
   logic signed [AZ_W-1:0]  az_in;
   logic signed [2*POS_W-1:0] sqx, sqy;
   logic [63:0]             rad_in;

   always_comb begin
      a0 = (ANG_W+1)'(req.tilt_angle);
      a1 = (a0 >= D180) ? a0 - D360 : a0;
      a2 = (a1 < -D180) ? a1 + D360 : a1;
      neg_in = 1'b0;
      a3 = a2;
      if (a2 > D90) begin
         a3 = a2 - D180;
         neg_in = 1'b1;
      end else if (a2 < -D90) begin
         a3 = a2 + D180;
         neg_in = 1'b1;
      end
      cut_in = req.tilt_angle;
      if (cut_in > AMAX) cut_in = AMAX;
      if (cut_in < AMIN) cut_in = AMIN;

      ax_raw = -(AT_W'(req.pos_y) <<< 8);
      ay_raw = AT_W'(req.pos_x) <<< 8;
      if (ax_raw < 0) begin
         ax_in = -ax_raw;
         ay_in = -ay_raw;
         az_in = (ay_raw >= 0) ? Z180 : -Z180;
      end else begin
         ax_in = ax_raw;
         ay_in = ay_raw;
         az_in = '0;
      end

      sqx    = (2*POS_W)'(req.pos_x) * (2*POS_W)'(req.pos_x);
      sqy    = (2*POS_W)'(req.pos_y) * (2*POS_W)'(req.pos_y);
      rad_in = (64'(unsigned'(sqx)) + 64'(unsigned'(sqy))) << 16;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (adv) v_ff[0] <= req.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0]   <= SC_W'(itk_pkg::GAIN_Q30);
         sy_ff[0]   <= '0;
         sz_ff[0]   <= SZ_W'(a3) <<< 16;
         neg_ff[0]  <= neg_in;
         ax_ff[0]   <= ax_in;
         ay_ff[0]   <= ay_in;
         az_ff[0]   <= az_in;
         zero_ff[0] <= (req.pos_x == '0) && (req.pos_y == '0);
         rem_ff[0]  <= rad_in;
         root_ff[0] <= '0;
         pz_ff[0]   <= req.pos_z;
         cut_ff[0]  <= cut_in;
      end
   end

   // iteration stages
   for (genvar k = 1; k <= DEPTH; k++) begin : g_stage
      localparam int I = k - 1;
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * I);
      logic [63:0] trial;

      assign trial = root_ff[k-1] + SQ_BIT;

      always_ff @(posedge clock) begin
         if (reset) v_ff[k] <= 1'b0;
         else if (adv) v_ff[k] <= v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            pz_ff[k]   <= pz_ff[k-1];
            cut_ff[k]  <= cut_ff[k-1];
            if (rem_ff[k-1] >= trial) begin
               rem_ff[k]  <= rem_ff[k-1] - trial;
               root_ff[k] <= (root_ff[k-1] >> 1) + SQ_BIT;
            end else begin
               rem_ff[k]  <= rem_ff[k-1];
               root_ff[k] <= root_ff[k-1] >> 1;
            end
         end
      end

      if (I < NSTEP) begin : g_cordic
         localparam logic signed [SZ_W-1:0] ATS =
            $signed({{(SZ_W-31){1'b0}}, itk_pkg::ATAN_TABLE[I]});
         localparam logic signed [AZ_W-1:0] ATA =
            $signed({{(AZ_W-31){1'b0}}, itk_pkg::ATAN_TABLE[I]});
         always_ff @(posedge clock) begin
            if (adv) begin
               if (sz_ff[k-1] >= 0) begin
                  sx_ff[k] <= sx_ff[k-1] - (sy_ff[k-1] >>> I);
                  sy_ff[k] <= sy_ff[k-1] + (sx_ff[k-1] >>> I);
                  sz_ff[k] <= sz_ff[k-1] - ATS;
               end else begin
                  sx_ff[k] <= sx_ff[k-1] + (sy_ff[k-1] >>> I);
                  sy_ff[k] <= sy_ff[k-1] - (sx_ff[k-1] >>> I);
                  sz_ff[k] <= sz_ff[k-1] + ATS;
               end
               if (ay_ff[k-1] >= 0) begin
                  ax_ff[k] <= ax_ff[k-1] + (ay_ff[k-1] >>> I);
                  ay_ff[k] <= ay_ff[k-1] - (ax_ff[k-1] >>> I);
                  az_ff[k] <= az_ff[k-1] + ATA;
               end else begin
                  ax_ff[k] <= ax_ff[k-1] - (ay_ff[k-1] >>> I);
                  ay_ff[k] <= ay_ff[k-1] + (ax_ff[k-1] >>> I);
                  az_ff[k] <= az_ff[k-1] - ATA;
               end
            end
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (adv) begin
               sx_ff[k] <= sx_ff[k-1];
               sy_ff[k] <= sy_ff[k-1];
               sz_ff[k] <= sz_ff[k-1];
               ax_ff[k] <= ax_ff[k-1];
               ay_ff[k] <= ay_ff[k-1];
               az_ff[k] <= az_ff[k-1];
            end
         end
      end
   end

   // multiply stage
   logic signed [SC_W-1:0]   sin_in, cos_in;
   logic signed [TURN_W+1:0] turn_wide;
   logic signed [TURN_W-1:0] turn_in;
   logic                     mul_v_ff;
   logic signed [PRD_W-1:0]  p_ys_ff, p_zc_ff, p_yc_ff, p_zs_ff;
   logic [32:0]              r8_ff;
   logic signed [POS_W-1:0]  mul_pz_ff;
   logic signed [ANG_W-1:0]  mul_cut_ff;
   logic signed [TURN_W-1:0] mul_turn_ff;

   always_comb begin
      sin_in = neg_ff[DEPTH] ? -sy_ff[DEPTH] : sy_ff[DEPTH];
      cos_in = neg_ff[DEPTH] ? -sx_ff[DEPTH] : sx_ff[DEPTH];
      turn_wide = (TURN_W+2)'((az_ff[DEPTH] + AZ_W'(32768)) >>> 16);
      if (zero_ff[DEPTH]) turn_wide = T180;
      else if (turn_wide > T180) turn_wide = T180;
      else if (turn_wide < -T180) turn_wide = -T180;
      turn_in = TURN_W'(turn_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) mul_v_ff <= 1'b0;
      else if (adv) mul_v_ff <= v_ff[DEPTH];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ys_ff     <= PRD_W'(tool_along_ff) * PRD_W'(sin_in);
         p_zc_ff     <= PRD_W'(tool_across_ff) * PRD_W'(cos_in);
         p_yc_ff     <= PRD_W'(tool_along_ff) * PRD_W'(cos_in);
         p_zs_ff     <= PRD_W'(tool_across_ff) * PRD_W'(sin_in);
         r8_ff       <= root_ff[DEPTH][32:0];
         mul_pz_ff   <= pz_ff[DEPTH];
         mul_cut_ff  <= cut_ff[DEPTH];
         mul_turn_ff <= turn_in;
      end
   end

   // sum stage
   logic                     sum_v_ff;
   logic signed [ACC_W-1:0]  acc_l_ff, acc_h_ff;
   logic signed [ANG_W-1:0]  sum_cut_ff;
   logic signed [TURN_W-1:0] sum_turn_ff;
   logic signed [ACC_W-1:0]  d_term, r_term, h_term;

   always_comb begin
      d_term = ACC_W'($signed({1'b0, arm_reach_ff})) <<< 30;
      r_term = ACC_W'($signed({1'b0, r8_ff})) <<< 22;
      h_term = (ACC_W'($signed({1'b0, base_height_ff})) - ACC_W'(mul_pz_ff)) <<< 30;
   end

   always_ff @(posedge clock) begin
      if (reset) sum_v_ff <= 1'b0;
      else if (adv) sum_v_ff <= mul_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_l_ff    <= d_term - r_term - ACC_W'(p_ys_ff) - ACC_W'(p_zc_ff);
         acc_h_ff    <= h_term + ACC_W'(p_yc_ff) - ACC_W'(p_zs_ff);
         sum_cut_ff  <= mul_cut_ff;
         sum_turn_ff <= mul_turn_ff;
      end
   end

   // round, clamp and output register
   localparam int RW = ACC_W - 30;
   localparam logic signed [RW-1:0] S24_MIN = RW'(-(longint'(1) <<< (POS_W - 1)));
   localparam logic signed [RW-1:0] S24_MAX = RW'((longint'(1) <<< (POS_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(longint'(1) <<< 29);

   logic signed [RW-1:0]    lift_r, height_r;
   logic signed [POS_W-1:0] lift_in, height_in;
   logic signed [POS_W-1:0] lift_ff, height_ff;
   logic signed [ANG_W-1:0] out_cut_ff;
   logic signed [TURN_W-1:0] out_turn_ff;

   always_comb begin
      lift_r = RW'((acc_l_ff + HALF) >>> 30);
      if (lift_r > RW'(lift_max_ff)) lift_r = RW'(lift_max_ff);
      if (lift_r < RW'(lift_min_ff) + RW'(itk_pkg::LIFT_MARGIN))
         lift_r = RW'(lift_min_ff) + RW'(itk_pkg::LIFT_MARGIN);
      if (lift_r > S24_MAX) lift_r = S24_MAX;
      if (lift_r < S24_MIN) lift_r = S24_MIN;
      lift_in = POS_W'(lift_r);

      height_r = RW'((acc_h_ff + HALF) >>> 30);
      if (height_r > RW'(height_max_ff)) height_r = RW'(height_max_ff);
      if (height_r < RW'(height_min_ff)) height_r = RW'(height_min_ff);
      height_in = POS_W'(height_r);
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= sum_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lift_ff     <= lift_in;
         height_ff   <= height_in;
         out_cut_ff  <= sum_cut_ff;
         out_turn_ff <= sum_turn_ff;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.lift       = lift_ff;
   assign rsp.height     = height_ff;
   assign rsp.cutter_out = out_cut_ff;
   assign rsp.turntable  = out_turn_ff;

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff[DEPTH]) && $stable(mul_v_ff) && $stable(sum_v_ff))
      else $error("pipeline moved while stalled");

   a_turn_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.turntable <= TURN_W'(itk_pkg::DEG180))
                 && (rsp.turntable >= -TURN_W'(itk_pkg::DEG180)))
      else $error("turntable out of range");

   a_cut_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (AMIN <= AMAX) |-> (rsp.cutter_out <= AMAX) && (rsp.cutter_out >= AMIN))
      else $error("cutter angle outside its limits");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid && !mul_v_ff && !sum_v_ff)
      else $error("pipeline not empty after reset");

endmodule

FILE: bench/itk_checker.sv
// Checker for the trimmer inverse kinematics block: predicts each response and compares it.
`timescale 1ns / 1ps
module itk_checker (
   input  logic        clock,
   input  logic        reset,
   itk_req_if.sink     req,
   itk_rsp_if.sink     rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [itk_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [itk_pkg::CSR_DW-1:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);
   localparam int POS_W  = itk_pkg::POS_W;
   localparam int ANG_W  = itk_pkg::ANG_W;
   localparam int TURN_W = itk_pkg::TURN_W;

   typedef struct packed {
      logic signed [POS_W-1:0]  lift;
      logic signed [POS_W-1:0]  height;
      logic signed [ANG_W-1:0]  cutter;
      logic signed [TURN_W-1:0] turn;
   } joints_type;

   localparam longint S24_LO = -64'sd8388608;
   localparam longint S24_HI = 64'sd8388607;

   longint geo [0:7];
   joints_type joints_q [$];

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void rotate(input longint a_in, output longint s, output longint c);
      longint a, x, y, z, t;
      bit flip;
      a = a_in;
      flip = 0;
      x = longint'(itk_pkg::GAIN_Q30);
      y = 0;
      if (a >= itk_pkg::DEG180) a -= itk_pkg::DEG360;
      if (a < -itk_pkg::DEG180) a += itk_pkg::DEG360;
      if (a > itk_pkg::DEG90) begin
         a -= itk_pkg::DEG180;
         flip = 1;
      end else if (a < -itk_pkg::DEG90) begin
         a += itk_pkg::DEG180;
         flip = 1;
      end
      z = a * 65536;
      for (int i = 0; i < itk_pkg::CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            t = x - shr(y, i); y = y + shr(x, i); x = t;
            z -= longint'(itk_pkg::ATAN_TABLE[i]);
         end else begin
            t = x + shr(y, i); y = y - shr(x, i); x = t;
            z += longint'(itk_pkg::ATAN_TABLE[i]);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint heading(longint yy, longint xx);
      longint x, y, z, t;
      x = xx * 256;
      y = yy * 256;
      z = 0;
      if (xx == 0 && yy == 0) return itk_pkg::DEG180;
      if (x < 0) begin
         z = (y >= 0) ? longint'(itk_pkg::DEG180) * 65536
                      : -longint'(itk_pkg::DEG180) * 65536;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < itk_pkg::CORDIC_STEPS; i++) begin
         if (y >= 0) begin
            t = x + shr(y, i); y = y - shr(x, i); x = t;
            z += longint'(itk_pkg::ATAN_TABLE[i]);
         end else begin
            t = x - shr(y, i); y = y + shr(x, i); x = t;
            z -= longint'(itk_pkg::ATAN_TABLE[i]);
         end
      end
      z = shr(z + 32768, 16);
      if (z > itk_pkg::DEG180) z = itk_pkg::DEG180;
      if (z < -itk_pkg::DEG180) z = -itk_pkg::DEG180;
      return z;
   endfunction

   function automatic longint root(longint unsigned n);
      longint unsigned r, rem, b;
      r = 0;
      rem = n;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint sat24(longint v);
      if (v > S24_HI) return S24_HI;
      if (v < S24_LO) return S24_LO;
      return v;
   endfunction

   function automatic joints_type solve_joints(longint px, longint py, longint pz,
                                               longint ang);
      longint s, c, acc, lf, ht, cu;
      joints_type j;
      rotate(ang, s, c);
      acc = geo[itk_pkg::REG_ARM_REACH] * (64'sd1 << 30)
          - root(longint'(px * px + py * py) << 16) * (64'sd1 << 22)
          - geo[itk_pkg::REG_TOOL_ALONG] * s - geo[itk_pkg::REG_TOOL_ACROSS] * c;
      lf = shr(acc + (64'sd1 << 29), 30);
      if (lf > geo[itk_pkg::REG_LIFT_MAX]) lf = geo[itk_pkg::REG_LIFT_MAX];
      if (lf < geo[itk_pkg::REG_LIFT_MIN] + itk_pkg::LIFT_MARGIN)
         lf = geo[itk_pkg::REG_LIFT_MIN] + itk_pkg::LIFT_MARGIN;
      acc = (geo[itk_pkg::REG_BASE_HEIGHT] - pz) * (64'sd1 << 30)
          + geo[itk_pkg::REG_TOOL_ALONG] * c - geo[itk_pkg::REG_TOOL_ACROSS] * s;
      ht = shr(acc + (64'sd1 << 29), 30);
      if (ht > geo[itk_pkg::REG_HEIGHT_MAX]) ht = geo[itk_pkg::REG_HEIGHT_MAX];
      if (ht < geo[itk_pkg::REG_HEIGHT_MIN]) ht = geo[itk_pkg::REG_HEIGHT_MIN];
      cu = ang;
      if (cu > itk_pkg::ANGLE_MAX) cu = itk_pkg::ANGLE_MAX;
      if (cu < itk_pkg::ANGLE_MIN) cu = itk_pkg::ANGLE_MIN;
      j.lift   = POS_W'(sat24(lf));
      j.height = POS_W'(sat24(ht));
      j.cutter = ANG_W'(cu);
      j.turn   = TURN_W'(heading(px, -py));
      return j;
   endfunction

   assign pending = joints_q.size();

   always @(posedge clock) begin
      joints_type want, got;
      int idx;
      if (reset) begin
         for (int i = 0; i < 8; i++) geo[i] = 0;
         fail_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            idx = int'(csr_paddr[4:2]);
            if (idx < 8) begin
               if (idx <= int'(itk_pkg::REG_BASE_HEIGHT))
                  geo[idx] = longint'(csr_pwdata[22:0]);
               else geo[idx] = longint'($signed(csr_pwdata[23:0]));
            end
         end
         if (rsp.valid && rsp.ready) begin
            got = {rsp.lift, rsp.height, rsp.cutter_out, rsp.turntable};
            if (joints_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = joints_q.pop_front();
               if (want !== got) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready)
            joints_q.push_back(solve_joints(req.pos_x, req.pos_y, req.pos_z,
                                            req.tilt_angle));
      end
   end
endmodule

FILE: bench/inverse_trimmer_kinematics_tb.sv
// Testbench top for the trimmer inverse kinematics block: stimulus, CSR phases and verdict.
`timescale 1ns / 1ps
module inverse_trimmer_kinematics_tb;
   localparam int CSR_AW = itk_pkg::CSR_AW;
   localparam int CSR_DW = itk_pkg::CSR_DW;
   localparam int LATENCY = 35;
   localparam int WATCHDOG = 20000;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending, idle_cycles;
   int send_idle, recv_stall;

   itk_req_if req ();
   itk_rsp_if rsp ();

   inverse_trimmer_kinematics u_dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   itk_checker u_checker (
      .clock, .reset, .req(req.sink), .rsp(rsp.sink),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .pending
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req.valid = 0;
      req.pos_x = 0;
      req.pos_y = 0;
      req.pos_z = 0;
      req.tilt_angle = 0;
      rsp.ready = 0;
   end

   always @(negedge clock) rsp.ready <= ($urandom_range(99) >= recv_stall);

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= CSR_AW'(idx) << 2; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic send_target(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                              logic [17:0] a);
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(negedge clock);
      end
      req.valid <= 1;
      req.pos_x <= x; req.pos_y <= y; req.pos_z <= z; req.tilt_angle <= a;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   function automatic logic [17:0] rand_angle();
      case ($urandom_range(3))
         0: return 18'($signed($urandom_range(184320)) - 92160);
         1: return 18'($signed($urandom_range(46080)) - 23040);
         2: return 18'($urandom);
         default: return 18'($signed($urandom_range(8)) - 4 + 23040 * $signed($urandom_range(8)) - 92160);
      endcase
   endfunction

   function automatic logic [23:0] rand_pos();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(131072)) - 65536);
         2: return 24'($signed($urandom_range(8)) - 4);
         default: return $urandom_range(1) ? 24'h7FFFFF - 24'($urandom_range(3))
                                            : 24'h800000 + 24'($urandom_range(3));
      endcase
   endfunction

   task automatic set_geometry(int mode);
      logic [31:0] v [0:7];
      case (mode)
         0: v = '{0, 0, 0, 0, 32'hFF800000, 32'h7FFFFF, 32'hFF800000, 32'h7FFFFF};
         1: v = '{32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF,
                  32'h7FFFFF, 32'h800000, 32'h7FFFFF, 32'h800000};
         2: v = '{32'h7FFFFF, 32'h7FFFFF, 32'h800000, 32'h800000,
                  32'hFF800000, 32'h7FFFFF, 32'hFF800000, 32'h7FFFFF};
         default: begin
            v[0] = $urandom_range(200000); v[1] = $urandom_range(200000);
            v[2] = 32'($signed($urandom_range(40000)) - 20000);
            v[3] = 32'($signed($urandom_range(40000)) - 20000);
            v[4] = 32'(-$signed($urandom_range(300000)));
            v[5] = $urandom_range(300000);
            v[6] = 32'(-$signed($urandom_range(300000)));
            v[7] = $urandom_range(300000);
         end
      endcase
      for (int i = 0; i < 8; i++) csr_write(3'(i), v[i]);
   endtask

   initial begin
      send_idle = 0;
      recv_stall = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      set_geometry(3);
      send_target(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 18'(23040));
      send_target(24'h800000, 24'h800000, 24'h800000, 18'(-23040));
      send_target(0, 0, 0, 0);
      send_target(0, 0, 24'h7FFFFF, 18'(92160));
      send_target(0, 24'd1000, 0, 18'(46080));
      send_target(0, -24'sd1000, 0, 18'(-46080));
      send_target(24'd1000, 0, 0, 18'(-92160));
      send_target(-24'sd1000, 0, 0, 18'(46079));
      send_target(-24'sd1, 24'd1, 0, 18'(23041));
      send_target(-24'sd1, -24'sd1, 0, 18'(-23041));
      send_target(24'h7FFFFF, 24'h800000, 0, 18'h1FFFF);
      send_target(24'h800000, 24'h7FFFFF, 0, 18'h20000);
      send_target(24'h555555, 24'hAAAAAA, 24'h555555, 18'h15555);
      send_target(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 18'h2AAAA);
      req.valid <= 0;
      for (int ph = 0; ph < 12; ph++) begin
         drain();
         set_geometry(ph < 3 ? ph : 3);
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 62; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 62; end
            default: begin send_idle = 19; recv_stall = 19; end
         endcase
         for (int n = 0; n < 120; n++) begin
            if (n == 60) begin
               req.valid <= 0;
               while (pending != 0) @(negedge clock);
            end
            send_target(rand_pos(), rand_pos(), rand_pos(), rand_angle());
         end
         req.valid <= 0;
      end
      recv_stall = 0;
      drain();
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

FILE: files.f
rtl/itk_pkg.sv
rtl/itk_if.sv
rtl/inverse_trimmer_kinematics.sv
bench/itk_checker.sv
bench/inverse_trimmer_kinematics_tb.sv
